// ===== hdl/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants of the stable priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int SPQ_DEPTH  = 16;
    localparam int SPQ_DATA_W = 32;
    localparam int SPQ_PRIO_W = 16;

    // Request kinds carried in req_type
    typedef enum logic {
        REQ_INSERT = 1'b0,
        REQ_REMOVE = 1'b1
    } t_spq_req;

    // Result status codes
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_spq_status;

    // Operation broadcast to every cell of the chain
    typedef struct packed {
        logic ins;
        logic rem;
    } t_spq_ctrl;

endpackage

// ===== hdl/spq_req_if.sv =====
// ----------------------------------------------------------------------------
// spq_req_if
// Request channel of the priority queue: valid/ready with insert or remove.
// ----------------------------------------------------------------------------
interface spq_req_if #(
    parameter int DATA_WIDTH     = 32,
    parameter int PRIORITY_WIDTH = 16
);
    logic                             valid;
    logic                             ready;
    logic                             req_type;
    logic        [DATA_WIDTH-1:0]     item_data;
    logic signed [PRIORITY_WIDTH-1:0] item_priority;

    modport source (output valid, req_type, item_data, item_priority, input ready);
    modport sink   (input valid, req_type, item_data, item_priority, output ready);
endinterface

// ===== hdl/spq_rsp_if.sv =====
// ----------------------------------------------------------------------------
// spq_rsp_if
// Result channel of the priority queue: status, head entry and fill count.
// ----------------------------------------------------------------------------
interface spq_rsp_if #(
    parameter int DATA_WIDTH     = 32,
    parameter int PRIORITY_WIDTH = 16,
    parameter int COUNT_WIDTH    = 5
);
    logic                             valid;
    logic                             ready;
    logic        [1:0]                status;
    logic                             head_valid;
    logic        [DATA_WIDTH-1:0]     head_data;
    logic signed [PRIORITY_WIDTH-1:0] head_priority;
    logic        [COUNT_WIDTH-1:0]    entry_count;

    modport source (output valid, status, head_valid, head_data, head_priority,
                    entry_count, input ready);
    modport sink   (input valid, status, head_valid, head_data, head_priority,
                    entry_count, output ready);
endinterface

// ===== hdl/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds an entry, shifts towards tail on insert
// and towards head on remove.
// ----------------------------------------------------------------------------
module spq_cell #(
    parameter int IDX            = 0,
    parameter int DEPTH          = 16,
    parameter int DATA_WIDTH     = 32,
    parameter int PRIORITY_WIDTH = 16
) (
    input  logic                                        i_clk,
    input  spq_pkg::t_spq_ctrl                          i_ctrl,
    input  logic        [$clog2(DEPTH+1)-1:0]           i_count,
    input  logic        [DATA_WIDTH-1:0]                i_new_data,
    input  logic signed [PRIORITY_WIDTH-1:0]            i_new_prio,
    input  logic                                        i_prev_keep,
    input  logic        [DATA_WIDTH-1:0]                i_prev_data,
    input  logic signed [PRIORITY_WIDTH-1:0]            i_prev_prio,
    input  logic        [DATA_WIDTH-1:0]                i_next_data,
    input  logic signed [PRIORITY_WIDTH-1:0]            i_next_prio,
    output logic        [DATA_WIDTH-1:0]                o_data,
    output logic signed [PRIORITY_WIDTH-1:0]            o_prio,
    output logic                                        o_keep
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH+1);

    logic        [DATA_WIDTH-1:0]     r_data, n_data;
    logic signed [PRIORITY_WIDTH-1:0] r_prio, n_prio;
    logic                             w_occupied;

    // slot holds a live entry when its index lies below the fill count
    assign w_occupied = (i_count > CNT_W'(IDX));
    // keep: a live entry of equal or higher priority stays ahead of the new one
    assign o_keep     = w_occupied && (r_prio >= i_new_prio);

    always_comb begin
        n_data = r_data;
        n_prio = r_prio;
        if (i_ctrl.ins) begin
            if (!o_keep) begin
                if (i_prev_keep) begin
                    n_data = i_new_data;
                    n_prio = i_new_prio;
                end else begin
                    n_data = i_prev_data;
                    n_prio = i_prev_prio;
                end
            end
        end else if (i_ctrl.rem) begin
            n_data = i_next_data;
            n_prio = i_next_prio;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_prio <= n_prio;
    end

    assign o_data = r_data;
    assign o_prio = r_prio;

endmodule

// ===== hdl/stable_priority_queue.sv =====
// ----------------------------------------------------------------------------
// stable_priority_queue
// Bounded priority queue kept sorted in a chain of cells, stable among equals.
// ----------------------------------------------------------------------------
// Result: registered on acceptance and presented in the next cycle.
// Throughput: one request per cycle unless stalled; every cell compares its
//   priority with the new one in the same cycle; the chain shifts in one step.
// Reset: synchronous, active low; clears the fill count and the result valid.
//   Cell contents are not cleared and are never read until written.
// ----------------------------------------------------------------------------
module stable_priority_queue #(
    parameter int DEPTH          = spq_pkg::SPQ_DEPTH,
    parameter int DATA_WIDTH     = spq_pkg::SPQ_DATA_W,
    parameter int PRIORITY_WIDTH = spq_pkg::SPQ_PRIO_W
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    spq_req_if.sink   i_req,
    spq_rsp_if.source o_rsp
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH+1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

    // per-cell outputs, each at its own place in the chain
    logic        [DATA_WIDTH-1:0]     w_data [DEPTH];
    logic signed [PRIORITY_WIDTH-1:0] w_prio [DEPTH];
    logic                             w_keep [DEPTH];

    logic                             w_accept;
    logic                             w_is_rem;
    logic                             w_full;
    logic                             w_empty;
    t_spq_ctrl                        w_ctrl;

    logic        [CNT_W-1:0]          r_count, n_count;

    // result register
    logic                             r_rsp_valid;
    t_spq_status                      r_status, n_status;
    logic                             r_head_valid, n_head_valid;
    logic        [DATA_WIDTH-1:0]     r_head_data, n_head_data;
    logic signed [PRIORITY_WIDTH-1:0] r_head_prio, n_head_prio;
    logic        [CNT_W-1:0]          r_rsp_count;

    // take a new request whenever the result register is free or draining
    assign i_req.ready = !r_rsp_valid || o_rsp.ready;
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_is_rem    = (i_req.req_type == REQ_REMOVE);
    assign w_full      = (r_count == FULL_COUNT);
    assign w_empty     = (r_count == '0);

    // drop an insert into a full queue and a remove from an empty one
    assign w_ctrl.ins = w_accept && !w_is_rem && !w_full;
    assign w_ctrl.rem = w_accept &&  w_is_rem && !w_empty;

    // ---- the chain ---------------------------------------------------------
    // Cells that keep their entry form a prefix; the first cell that does not
    // keep takes the new entry and every later cell takes its predecessor's.
    // On remove each cell takes its successor's entry.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic                             w_prev_keep;
        logic        [DATA_WIDTH-1:0]     w_prev_data;
        logic signed [PRIORITY_WIDTH-1:0] w_prev_prio;
        logic        [DATA_WIDTH-1:0]     w_next_data;
        logic signed [PRIORITY_WIDTH-1:0] w_next_prio;

        if (g == 0) begin : g_head
            assign w_prev_keep = 1'b1;
            assign w_prev_data = i_req.item_data;
            assign w_prev_prio = i_req.item_priority;
        end else begin : g_body
            assign w_prev_keep = w_keep[g-1];
            assign w_prev_data = w_data[g-1];
            assign w_prev_prio = w_prio[g-1];
        end

        if (g == DEPTH-1) begin : g_tail
            // tail slot falls out of the count on remove; hold its contents
            assign w_next_data = w_data[g];
            assign w_next_prio = w_prio[g];
        end else begin : g_inner
            assign w_next_data = w_data[g+1];
            assign w_next_prio = w_prio[g+1];
        end

        spq_cell #(
            .IDX            (g),
            .DEPTH          (DEPTH),
            .DATA_WIDTH     (DATA_WIDTH),
            .PRIORITY_WIDTH (PRIORITY_WIDTH)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (w_ctrl),
            .i_count     (r_count),
            .i_new_data  (i_req.item_data),
            .i_new_prio  (i_req.item_priority),
            .i_prev_keep (w_prev_keep),
            .i_prev_data (w_prev_data),
            .i_prev_prio (w_prev_prio),
            .i_next_data (w_next_data),
            .i_next_prio (w_next_prio),
            .o_data      (w_data[g]),
            .o_prio      (w_prio[g]),
            .o_keep      (w_keep[g])
        );
    end

    // ---- fill count and result ---------------------------------------------
    always_comb begin
        n_count = r_count;
        if (w_ctrl.ins) begin
            n_count = r_count + 1'b1;
        end else if (w_ctrl.rem) begin
            n_count = r_count - 1'b1;
        end

        n_status = ST_DONE;
        if (w_is_rem && w_empty) begin
            n_status = ST_EMPTY;
        end else if (!w_is_rem && w_full) begin
            n_status = ST_FULL;
        end

        // head after the step: mirror what cell 0 is about to load
        if (w_ctrl.rem) begin
            n_head_data = w_data[1];
            n_head_prio = w_prio[1];
        end else if (w_ctrl.ins && !w_keep[0]) begin
            n_head_data = i_req.item_data;
            n_head_prio = i_req.item_priority;
        end else begin
            n_head_data = w_data[0];
            n_head_prio = w_prio[0];
        end

        // report zeros once the queue is empty
        n_head_valid = (n_count != '0);
        if (!n_head_valid) begin
            n_head_data = '0;
            n_head_prio = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_rsp_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    // result payload: load on acceptance, hold while stalled
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status     <= n_status;
            r_head_valid <= n_head_valid;
            r_head_data  <= n_head_data;
            r_head_prio  <= n_head_prio;
            r_rsp_count  <= n_count;
        end
    end

    assign o_rsp.valid         = r_rsp_valid;
    assign o_rsp.status        = r_status;
    assign o_rsp.head_valid    = r_head_valid;
    assign o_rsp.head_data     = r_head_data;
    assign o_rsp.head_priority = r_head_prio;
    assign o_rsp.entry_count   = r_rsp_count;

    // ---- checks -------------------------------------------------------------
`ifndef ASSERT_OFF
    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_COUNT)
        else $error("fill count beyond depth");

    a_insert_grows : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.ins |=> (r_count == $past(r_count) + 1'b1))
        else $error("accepted insert did not grow the queue");

    a_head_matches_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rsp_valid |-> (r_head_valid == (r_rsp_count != '0)))
        else $error("head valid disagrees with entry count");

    a_full_status : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rsp_valid && r_status == ST_FULL) |-> (r_rsp_count == FULL_COUNT))
        else $error("full rejection reported on a queue that is not full");
`endif

endmodule

// ===== tb/tb_stable_priority_queue.sv =====
// ----------------------------------------------------------------------------
// tb_stable_priority_queue
// Self-checking bench for the stable priority queue. Requests go in on the
// request channel, a shadow copy of the sorted queue predicts each result,
// and every result taken from the result channel is compared field by field.
// ----------------------------------------------------------------------------
module tb_stable_priority_queue;
    import spq_pkg::*;

    localparam logic signed [SPQ_PRIO_W-1:0] RANK_MIN = 16'sh8000;
    localparam logic signed [SPQ_PRIO_W-1:0] RANK_MAX = 16'sh7FFF;

    // What the queue reports after one request
    typedef struct packed {
        t_spq_status                    status;
        logic                           head_valid;
        logic        [SPQ_DATA_W-1:0]   head_data;
        logic signed [SPQ_PRIO_W-1:0]   head_priority;
        logic        [4:0]              entry_count;
    } t_queue_view;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    spq_req_if #(.DATA_WIDTH(SPQ_DATA_W), .PRIORITY_WIDTH(SPQ_PRIO_W)) req_bus ();
    spq_rsp_if #(.DATA_WIDTH(SPQ_DATA_W), .PRIORITY_WIDTH(SPQ_PRIO_W),
                 .COUNT_WIDTH(5)) rsp_bus ();

    stable_priority_queue DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow of the sorted queue: head at slot 0, stable among equal ranks
    logic        [SPQ_DATA_W-1:0] shadow_data [SPQ_DEPTH];
    logic signed [SPQ_PRIO_W-1:0] shadow_rank [SPQ_DEPTH];
    int                           shadow_fill = 0;

    // Views still owed by the queue, oldest first
    t_queue_view awaited_views[$];

    int fail_count     = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // Apply one request to the shadow queue and return the view it leaves.
    function automatic t_queue_view apply_to_shadow(t_spq_req kind,
                                                    logic [SPQ_DATA_W-1:0] data,
                                                    logic signed [SPQ_PRIO_W-1:0] rank);
        t_queue_view view;
        int          slot;
        int          idx;
        view = '0;
        view.status = ST_DONE;
        if (kind == REQ_INSERT) begin
            if (shadow_fill >= SPQ_DEPTH) begin
                // Drop the new entry; a full queue rejects even the highest rank
                view.status = ST_FULL;
            end else begin
                // Walk past every stored entry of equal or higher rank
                slot = 0;
                while (slot < shadow_fill && shadow_rank[slot] >= rank)
                    slot++;
                for (idx = shadow_fill; idx > slot; idx--) begin
                    shadow_data[idx] = shadow_data[idx-1];
                    shadow_rank[idx] = shadow_rank[idx-1];
                end
                shadow_data[slot] = data;
                shadow_rank[slot] = rank;
                shadow_fill++;
            end
        end else begin
            if (shadow_fill == 0) begin
                // Leave an empty queue untouched and flag the request
                view.status = ST_EMPTY;
            end else begin
                for (idx = 0; idx + 1 < shadow_fill; idx++) begin
                    shadow_data[idx] = shadow_data[idx+1];
                    shadow_rank[idx] = shadow_rank[idx+1];
                end
                shadow_fill--;
            end
        end
        if (shadow_fill > 0) begin
            view.head_valid    = 1'b1;
            view.head_data     = shadow_data[0];
            view.head_priority = shadow_rank[0];
        end
        view.entry_count = shadow_fill[4:0];
        return view;
    endfunction

    // Present one request, idling first at the current sender rate, and hold
    // it until the queue takes it; then record the view it must produce.
    task automatic send_request(t_spq_req kind, logic [SPQ_DATA_W-1:0] data,
                                logic signed [SPQ_PRIO_W-1:0] rank);
        while ($urandom_range(99) < send_idle_pct) begin
            req_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_bus.valid         <= 1'b1;
        req_bus.req_type      <= kind;
        req_bus.item_data     <= data;
        req_bus.item_priority <= rank;
        @(posedge i_clk);
        while (!req_bus.ready)
            @(posedge i_clk);
        awaited_views.push_back(apply_to_shadow(kind, data, rank));
    endtask

    // Drive the result side: stall at the current receiver rate.
    always @(posedge i_clk) begin
        rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic void compare_field(string field, logic [31:0] want,
                                          logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            fail_count++;
        end
    endfunction

    // Check every result taken against the oldest view owed.
    always @(posedge i_clk) begin : result_check
        t_queue_view want;
        if (i_rst_n && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            if (awaited_views.size() == 0) begin
                $error("result with no request outstanding");
                fail_count++;
            end else begin
                want = awaited_views.pop_front();
                compare_field("status", 32'(want.status), 32'(rsp_bus.status));
                compare_field("head_valid", 32'(want.head_valid),
                              32'(rsp_bus.head_valid));
                compare_field("head_data", want.head_data, rsp_bus.head_data);
                compare_field("head_priority", 32'(want.head_priority),
                              32'(rsp_bus.head_priority));
                compare_field("entry_count", 32'(want.entry_count),
                              32'(rsp_bus.entry_count));
            end
        end
    end

    // Remove on an empty queue: flag it and report zero head fields.
    task automatic test_remove_on_empty;
        send_request(REQ_REMOVE, 32'hFFFF_FFFF, RANK_MAX);
        send_request(REQ_REMOVE, 32'h0000_0000, RANK_MIN);
    endtask

    // Extremes of data and rank, and a tie with the current head.
    task automatic test_field_extremes;
        send_request(REQ_INSERT, 32'h0000_0000, RANK_MIN);
        send_request(REQ_INSERT, 32'hFFFF_FFFF, RANK_MAX);
        send_request(REQ_INSERT, 32'hA5A5_A5A5, 16'sh0000);
        send_request(REQ_INSERT, 32'h5A5A_5A5A, -16'sd1);
        // Equal to the head: must queue behind it
        send_request(REQ_INSERT, 32'h0000_0001, RANK_MAX);
        send_request(REQ_REMOVE, 32'h0, 16'sh0);
    endtask

    // Fill to the brim with many ties, hit the full case, then free a slot.
    task automatic test_fill_and_reject;
        int k;
        for (k = 0; k < 12; k++)
            send_request(REQ_INSERT, 32'h1000_0000 + k, (k % 3 == 0) ? 16'sh0 : -16'sd5);
        send_request(REQ_INSERT, 32'hDEAD_BEEF, RANK_MAX);
        send_request(REQ_REMOVE, 32'h0, 16'sh0);
        send_request(REQ_INSERT, 32'hCAFE_F00D, -16'sd5);
        send_request(REQ_INSERT, 32'h0BAD_F00D, RANK_MIN);
    endtask

    // Random traffic across four flow-control phases. Runs of requests lean
    // towards inserts or removes, so the queue swings between full and empty;
    // ranks are drawn narrow often enough to make ties common.
    task automatic test_random_traffic;
        int                           send_idle_by_phase [4] = '{0, 79, 0, 8};
        int                           recv_stall_by_phase[4] = '{0, 0, 79, 8};
        int                           phase;
        int                           item;
        int                           insert_pct;
        t_spq_req                     kind;
        logic        [SPQ_DATA_W-1:0] data;
        logic signed [SPQ_PRIO_W-1:0] rank;
        insert_pct = 50;
        for (phase = 0; phase < 4; phase++) begin
            send_idle_pct  = send_idle_by_phase[phase];
            recv_stall_pct = recv_stall_by_phase[phase];
            for (item = 0; item < 440; item++) begin
                if (item % 40 == 0) begin
                    case ($urandom_range(2))
                        0:       insert_pct = 25;
                        1:       insert_pct = 50;
                        default: insert_pct = 85;
                    endcase
                end
                kind = ($urandom_range(99) < insert_pct) ? REQ_INSERT : REQ_REMOVE;
                data = $urandom();
                case ($urandom_range(3))
                    0:       rank = SPQ_PRIO_W'($urandom());
                    1:       rank = SPQ_PRIO_W'($signed($urandom_range(4)) - 2);
                    2: begin
                        case ($urandom_range(3))
                            0:       rank = RANK_MIN;
                            1:       rank = RANK_MAX;
                            2:       rank = 16'sh0;
                            default: rank = -16'sd1;
                        endcase
                    end
                    default: rank = SPQ_PRIO_W'($signed($urandom_range(15)) - 8);
                endcase
                send_request(kind, data, rank);
            end
        end
    endtask

    initial begin
        req_bus.valid         = 1'b0;
        req_bus.req_type      = REQ_INSERT;
        req_bus.item_data     = '0;
        req_bus.item_priority = '0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_remove_on_empty();
        test_field_extremes();
        test_fill_and_reject();
        test_random_traffic();

        // Withdraw the last request and let the result side drain
        req_bus.valid  <= 1'b0;
        recv_stall_pct = 0;
        while (awaited_views.size() != 0)
            @(posedge i_clk);
        // Keep the clock running to catch any stray result
        repeat (4) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Abandon a hung run
    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
